FILE: rtl/pulse_width_bit_slicer_macros.svh
// Assertion macros for the pulse width bit slicer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PULSE_WIDTH_BIT_SLICER_MACROS_SVH
`define PULSE_WIDTH_BIT_SLICER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk, off while rst_n is low.
`define PWBS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define PWBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PWBS_ASSERT_CLK(label, prop, msg)
`define PWBS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/pwbs_pkg.sv
// Shared types and constants for the pulse width bit slicer.
// No dependencies; used by the interfaces, controller, datapath and top level.
package pwbs_pkg;

    localparam int WIDTH_W            = 16;
    localparam int MAX_PULSES_DEFAULT = 64;
    localparam int MIN_PULSES         = 2;
    localparam logic [WIDTH_W-1:0] TOLERANCE_RESET = 16'd50;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_READ,
        ST_SEND,
        ST_EMPTY
    } pwbs_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // accept a pulse word
        logic clear_burst; // end of burst
        logic latch_thr;
        logic idx_clear;
        logic idx_inc;
        logic rd_issue;    // read store at idx
        logic out_load;
        logic out_empty;   // the loaded result is the empty one
    } pwbs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic too_few;
        logic second_found;
        logic idx_last;
        logic out_free;
    } pwbs_status_t;

endpackage

FILE: rtl/pwbs_if.sv
// Valid/ready channel interfaces: pulse input, bit output, tolerance write.
// Depends on pwbs_pkg.
interface pwbs_in_if
    import pwbs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] width_us;
    logic               last;

    modport source (output valid, output width_us, output last, input ready);
    modport sink   (input valid, input width_us, input last, output ready);
endinterface

interface pwbs_out_if
    import pwbs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               bit_res;
    logic               last_bit;
    logic               empty_res;
    logic               overflow;
    logic [WIDTH_W-1:0] threshold;

    modport source (output valid, output bit_res, output last_bit, output empty_res,
                    output overflow, output threshold, input ready);
    modport sink   (input valid, input bit_res, input last_bit, input empty_res,
                    input overflow, input threshold, output ready);
endinterface

interface pwbs_cfg_if
    import pwbs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pwbs_ctrl.sv
// Controller state machine of the pulse width bit slicer.
// Depends on pwbs_pkg; drives the datapath commands only.
module pwbs_ctrl
    import pwbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_last,
    output logic         in_ready,
    input  pwbs_status_t status,
    output pwbs_cmd_t    cmd
);

    pwbs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                // counters now include the final pulse
                if (status.too_few || !status.second_found)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    cmd.latch_thr = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.clear_burst = 1'b1;
                        state_next      = ST_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_empty   = 1'b1;
                    cmd.clear_burst = 1'b1;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/pwbs_datapath.sv
// Datapath of the pulse width bit slicer: pulse store, cluster tracking,
// threshold, read index and output register. Depends on pwbs_pkg and the macros header.
`include "pulse_width_bit_slicer_macros.svh"

module pwbs_datapath
    import pwbs_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pwbs_cmd_t          cmd,
    output pwbs_status_t       status,
    input  logic [WIDTH_W-1:0] in_width_us,
    input  logic               cfg_valid,
    input  logic [WIDTH_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_bit_res,
    output logic               out_last_bit,
    output logic               out_empty_res,
    output logic               out_overflow,
    output logic [WIDTH_W-1:0] out_threshold
);

    localparam int CNT_W = $clog2(MAX_PULSES + 1);
    localparam int IDX_W = $clog2(MAX_PULSES);

    logic [WIDTH_W-1:0] store_mem [MAX_PULSES];

    logic [WIDTH_W-1:0] tol_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               found_reg;
    logic               ovf_reg;
    logic [WIDTH_W-1:0] ref_reg;
    logic [WIDTH_W-1:0] second_reg;
    logic [WIDTH_W-1:0] thr_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WIDTH_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic               bit_reg;
    logic               last_reg;
    logic               empty_reg;
    logic               ovf_out_reg;
    logic [WIDTH_W-1:0] thr_out_reg;

    logic               has_room;
    logic [WIDTH_W-1:0] diff;
    logic [WIDTH_W:0]   sum;
    logic               idx_last;

    assign has_room = count_reg < CNT_W'(MAX_PULSES);
    assign diff     = (in_width_us >= ref_reg) ? (in_width_us - ref_reg)
                                               : (ref_reg - in_width_us);
    assign sum      = {1'b0, ref_reg} + {1'b0, second_reg};
    assign idx_last = CNT_W'(idx_reg) == (count_reg - CNT_W'(1));

    assign status.too_few      = count_reg < CNT_W'(MIN_PULSES);
    assign status.second_found = found_reg;
    assign status.idx_last     = idx_last;
    assign status.out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOLERANCE_RESET;
            count_reg <= '0;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end
            if (cmd.clear_burst)
            begin
                count_reg <= '0;
                found_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (count_reg != '0 && !found_reg && diff > tol_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= in_width_us;
            if (count_reg == '0)
            begin
                ref_reg <= in_width_us;
            end
            else if (!found_reg && diff > tol_reg)
            begin
                second_reg <= in_width_us;
            end
        end
        if (cmd.latch_thr)
        begin
            thr_reg <= sum[WIDTH_W:1];
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ovf_out_reg <= ovf_reg;
            if (cmd.out_empty)
            begin
                bit_reg     <= 1'b0;
                last_reg    <= 1'b1;
                empty_reg   <= 1'b1;
                thr_out_reg <= '0;
            end
            else
            begin
                bit_reg     <= rd_data_reg > thr_reg;
                last_reg    <= idx_last;
                empty_reg   <= 1'b0;
                thr_out_reg <= thr_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_bit_res   = bit_reg;
    assign out_last_bit  = last_reg;
    assign out_empty_res = empty_reg;
    assign out_overflow  = ovf_out_reg;
    assign out_threshold = thr_out_reg;

    `PWBS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_PULSES), "pulse count past capacity")
    `PWBS_ASSERT_CLK(a_load_free, cmd.out_load |-> (!out_valid_reg || out_ready), "result overwritten")
    `PWBS_ASSERT_CLK(a_load_clear, !(cmd.load && cmd.clear_burst), "pulse taken at burst end")
    `PWBS_ASSERT_CLK(a_read_range, cmd.rd_issue |-> (CNT_W'(idx_reg) < count_reg), "read of unwritten entry")

endmodule

FILE: rtl/pulse_width_bit_slicer.sv
// Top level of the pulse width bit slicer: controller plus datapath.
// Depends on pwbs_pkg, the channel interfaces, pwbs_ctrl and pwbs_datapath.
//
// Usage:
//   pulse_in  - one word per pulse width in us; last marks the burst end.
//   bit_out   - one word per stored pulse after the burst end, or a single
//               empty word when fewer than two pulses or no second cluster.
//   cfg       - writes tolerance_us (reset 50); always ready, write only
//               while the block is idle.
// Throughput: non-final pulses are taken one per cycle. After the final
// pulse the controller makes the decision in ST_DECIDE, then walks the
// store one result at a time: a store read in ST_READ, then the output
// register load in ST_SEND, and each read waits until the previous result
// is loaded. pulse_in is held off during the walk and reopens when the
// last result is loaded, even while it waits.
// Pulses past MAX_PULSES are dropped and flag overflow.
// Reset clears the burst counters and the output valid; store contents are
// not cleared. A stalled receiver holds the current result and the walk.
module pulse_width_bit_slicer
    import pwbs_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    pwbs_in_if.sink    pulse_in,
    pwbs_out_if.source bit_out,
    pwbs_cfg_if.sink   cfg
);

    pwbs_cmd_t    cmd;
    pwbs_status_t status;

    assign cfg.ready = 1'b1;

    pwbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pulse_in.valid),
        .in_last  (pulse_in.last),
        .in_ready (pulse_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pwbs_datapath #(
        .MAX_PULSES (MAX_PULSES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_width_us   (pulse_in.width_us),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.data),
        .out_valid     (bit_out.valid),
        .out_ready     (bit_out.ready),
        .out_bit_res   (bit_out.bit_res),
        .out_last_bit  (bit_out.last_bit),
        .out_empty_res (bit_out.empty_res),
        .out_overflow  (bit_out.overflow),
        .out_threshold (bit_out.threshold)
    );

endmodule
